// ===== design/kcu_pkg.sv =====
// Shared types and constants for the KeeLoq cipher unit.
// No dependencies; every other design file but kcu_if imports this package.
package kcu_pkg;

  // Command codes carried by the input item
  typedef enum logic [1:0] {
    CMD_ENCRYPT       = 2'd0,
    CMD_DECRYPT       = 2'd1,
    CMD_NORMAL_KEYGEN = 2'd2,
    CMD_SECURE_KEYGEN = 2'd3
  } kcu_cmd_e;

  // Register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_CIPHER_KEY  = 2'd0;
  localparam logic [1:0] REG_ROUND_COUNT = 2'd1;
  localparam logic [1:0] REG_NLF_TABLE   = 2'd2;

  localparam int unsigned AddrWidth = 5;

  // Register reset values
  localparam logic [63:0] CIPHER_KEY_RST  = 64'h0;
  localparam logic [15:0] ROUND_COUNT_RST = 16'd528;
  localparam logic [31:0] NLF_TABLE_RST   = 32'h3A5C742E;

  // Key generation constants
  localparam logic [15:0] KEYGEN_ROUNDS   = 16'd528;
  localparam logic [31:0] SERIAL_MASK     = 32'h0fffffff;
  localparam logic [31:0] NORMAL_LOW_TAG  = 32'h20000000;
  localparam logic [31:0] NORMAL_HIGH_TAG = 32'h60000000;

  // Decrypt walks the key from bit 15 downward, modulo 64
  localparam logic [5:0] DEC_KEY_START = 6'd15;
  localparam logic [5:0] ENC_KEY_START = 6'd0;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture an accepted item, set up the first pass
    logic second;    // set up the second key generation pass
    logic step;      // run one cipher round
    logic out_load;  // write the result into the output register
  } kcu_ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero;  // no rounds left in the current pass
    logic keygen;    // current item is a key generation command
  } kcu_dp_status_t;

endpackage

// ===== design/kcu_if.sv =====
// Valid/ready channel interfaces for the KeeLoq cipher unit.
// Input channel carries the command item, output channel the result item.
interface kcu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] block_in;
  logic [31:0] serial_in;

  modport source (output valid, output command, output block_in, output serial_in,
                  input ready);
  modport sink   (input valid, input command, input block_in, input serial_in,
                  output ready);
endinterface

interface kcu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_out;
  logic [63:0] derived_key;

  modport source (output valid, output block_out, output derived_key, input ready);
  modport sink   (input valid, input block_out, input derived_key, output ready);
endinterface

// ===== design/keeloq_cipher_unit_top.sv =====
// KeeLoq cipher unit: 32-bit block cipher with encrypt, decrypt and key generation.
// Depends on kcu_pkg, kcu_if, kcu_cfg_regs, kcu_ctrl and kcu_datapath.
//
// Usage:
//   The input channel (in_i) takes one item: a command, a data block or seed,
//   and a serial number. The output channel (out_o) returns one result item per
//   input item: the cipher block, or the derived 64-bit key for key generation.
//   The APB port writes the 64-bit key, the round count and the NLF table at
//   byte addresses 0, 8 and 16; write it only while no item is in flight.
//   The shared NLFSR datapath runs one cipher round per cycle. Encrypt and
//   decrypt run round_count rounds; key generation runs two 528-round passes.
//   One item is worked on at a time and the next is accepted the cycle after
//   the result loads.
//   A finished result sits in the output register; the next item is accepted
//   while it waits. If the receiver stalls, a second finished result waits in
//   the datapath until the output register frees.
//   Reset clears the controller, empties the output register and restores the
//   registers to key 0, 528 rounds and NLF table 0x3A5C742E.
module keeloq_cipher_unit_top import kcu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  kcu_in_if.sink               in_i,
  kcu_out_if.source            out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  logic [63:0]    cipher_key;
  logic [15:0]    round_count;
  logic [31:0]    nlf_table;
  kcu_ctrl_cmd_t  ctrl_cmd;
  kcu_dp_status_t dp_status;

  kcu_cfg_regs u_cfg_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cipher_key_o  (cipher_key),
    .round_count_o (round_count),
    .nlf_table_o   (nlf_table)
  );

  kcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  kcu_datapath u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (ctrl_cmd),
    .status_o      (dp_status),
    .command_i     (in_i.command),
    .block_in_i    (in_i.block_in),
    .serial_in_i   (in_i.serial_in),
    .cipher_key_i  (cipher_key),
    .round_count_i (round_count),
    .nlf_table_i   (nlf_table),
    .block_out_o   (out_o.block_out),
    .derived_key_o (out_o.derived_key)
  );

endmodule

// ===== design/kcu_cfg_regs.sv =====
// APB-style configuration registers: cipher key, round count, NLF table.
// Depends on kcu_pkg for register indexes and reset values.
module kcu_cfg_regs import kcu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output logic [63:0]          cipher_key_o,
  output logic [15:0]          round_count_o,
  output logic [31:0]          nlf_table_o
);

  logic [63:0] cipher_key_q;
  logic [15:0] round_count_q;
  logic [31:0] nlf_table_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];

  // Write on the access phase; addresses past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q  <= CIPHER_KEY_RST;
      round_count_q <= ROUND_COUNT_RST;
      nlf_table_q   <= NLF_TABLE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CIPHER_KEY:  cipher_key_q  <= pwdata;
        REG_ROUND_COUNT: round_count_q <= pwdata[15:0];
        REG_NLF_TABLE:   nlf_table_q   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_CIPHER_KEY:  prdata = cipher_key_q;
      REG_ROUND_COUNT: prdata = {48'h0, round_count_q};
      REG_NLF_TABLE:   prdata = {32'h0, nlf_table_q};
      default:         prdata = 64'h0;
    endcase
  end

  assign cipher_key_o  = cipher_key_q;
  assign round_count_o = round_count_q;
  assign nlf_table_o   = nlf_table_q;

endmodule

// ===== design/kcu_datapath.sv =====
// KeeLoq datapath: NLFSR block register, key bit pointer, round counter,
// and the output payload register. Depends on kcu_pkg.
module kcu_datapath import kcu_pkg::*; (
  input  logic           clk_i,
  input  kcu_ctrl_cmd_t  cmd_i,
  output kcu_dp_status_t status_o,
  input  logic [1:0]     command_i,
  input  logic [31:0]    block_in_i,
  input  logic [31:0]    serial_in_i,
  input  logic [63:0]    cipher_key_i,
  input  logic [15:0]    round_count_i,
  input  logic [31:0]    nlf_table_i,
  output logic [31:0]    block_out_o,
  output logic [63:0]    derived_key_o
);

  logic [1:0]  cmd_q;
  logic [31:0] blk_q, blk_d;
  logic [31:0] sec_q;
  logic [31:0] lo_q;
  logic [15:0] cnt_q;
  logic [5:0]  kpos_q, kpos_d;
  logic [31:0] block_out_q;
  logic [63:0] derived_key_q;

  logic [31:0] ser_masked;
  logic [31:0] first_word;
  logic [31:0] second_word;
  logic [15:0] first_rounds;
  logic        in_decrypt;
  logic        run_decrypt;
  logic        run_keygen;
  logic [4:0]  nlf_idx;
  logic        key_bit;
  logic        new_bit;

  assign run_keygen  = (cmd_q == CMD_NORMAL_KEYGEN) || (cmd_q == CMD_SECURE_KEYGEN);
  assign run_decrypt = (cmd_q != CMD_ENCRYPT);

  // Select the words and round count for an incoming item
  assign ser_masked = serial_in_i & SERIAL_MASK;
  assign in_decrypt = (command_i != CMD_ENCRYPT);
  always_comb begin
    case (command_i)
      CMD_NORMAL_KEYGEN: begin
        first_word   = ser_masked | NORMAL_LOW_TAG;
        second_word  = ser_masked | NORMAL_HIGH_TAG;
        first_rounds = KEYGEN_ROUNDS;
      end
      CMD_SECURE_KEYGEN: begin
        first_word   = block_in_i;
        second_word  = ser_masked;
        first_rounds = KEYGEN_ROUNDS;
      end
      default: begin
        first_word   = block_in_i;
        second_word  = ser_masked;
        first_rounds = round_count_i;
      end
    endcase
  end

  // One cipher round in either direction
  assign key_bit = cipher_key_i[kpos_q];
  always_comb begin
    if (run_decrypt) begin
      nlf_idx = {blk_q[30], blk_q[25], blk_q[19], blk_q[8], blk_q[0]};
      new_bit = key_bit ^ blk_q[31] ^ blk_q[15] ^ nlf_table_i[nlf_idx];
      blk_d   = {blk_q[30:0], new_bit};
      kpos_d  = kpos_q - 6'd1;
    end else begin
      nlf_idx = {blk_q[31], blk_q[26], blk_q[20], blk_q[9], blk_q[1]};
      new_bit = key_bit ^ blk_q[16] ^ blk_q[0] ^ nlf_table_i[nlf_idx];
      blk_d   = {new_bit, blk_q[31:1]};
      kpos_d  = kpos_q + 6'd1;
    end
  end

  // Load, reload for the second pass, or advance one round
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      blk_q  <= first_word;
      sec_q  <= second_word;
      cnt_q  <= first_rounds;
      kpos_q <= in_decrypt ? DEC_KEY_START : ENC_KEY_START;
    end else if (cmd_i.second) begin
      lo_q   <= blk_q;
      blk_q  <= sec_q;
      cnt_q  <= KEYGEN_ROUNDS;
      kpos_q <= DEC_KEY_START;
    end else if (cmd_i.step) begin
      blk_q  <= blk_d;
      cnt_q  <= cnt_q - 16'd1;
      kpos_q <= kpos_d;
    end
  end

  // Hold the finished result until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      block_out_q   <= run_keygen ? 32'h0 : blk_q;
      derived_key_q <= run_keygen ? {blk_q, lo_q} : 64'h0;
    end
  end

  assign status_o.cnt_zero = (cnt_q == 16'd0);
  assign status_o.keygen   = run_keygen;
  assign block_out_o       = block_out_q;
  assign derived_key_o     = derived_key_q;

endmodule

// ===== design/kcu_ctrl.sv =====
// KeeLoq controller: sequences accept, round passes and result hand-off.
// Depends on kcu_pkg for the command and status structs.
module kcu_ctrl import kcu_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  kcu_dp_status_t status_i,
  output kcu_ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       second_q, second_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // Next state and datapath commands
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          second_d   = 1'b0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status_i.cnt_zero) begin
          cmd_o.step = 1'b1;
        end else if (status_i.keygen && !second_q) begin
          cmd_o.second = 1'b1;
          second_d     = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Set valid on load, drop it once the item is taken
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts_first_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_RUN && !second_q))
    else $error("accepted item did not start its first pass");

  a_second_pass_keygen_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.second |-> (status_i.keygen && !second_q && status_i.cnt_zero))
    else $error("second pass outside key generation");

  a_result_valid_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_valid_o && state_q == ST_IDLE))
    else $error("result load did not raise valid");

endmodule

// ===== sim/keeloq_check_pkg.sv =====
// Result predictor and scoreboard for the KeeLoq cipher unit testbench.
// Depends on kcu_pkg for command codes, register indexes and reset values.
package keeloq_check_pkg;
  import kcu_pkg::*;

  typedef struct packed {
    logic [31:0] block;
    logic [63:0] dkey;
  } cipher_result_t;

  class keeloq_scoreboard;
    logic [63:0]    key;
    logic [15:0]    rounds;
    logic [31:0]    nlf;
    cipher_result_t expected_q[$];
    int unsigned    mismatches;

    function new();
      key        = CIPHER_KEY_RST;
      rounds     = ROUND_COUNT_RST;
      nlf        = NLF_TABLE_RST;
      mismatches = 0;
    endfunction

    // Mirror a register write
    function void write_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_CIPHER_KEY:  key    = value;
        REG_ROUND_COUNT: rounds = value[15:0];
        REG_NLF_TABLE:   nlf    = value[31:0];
        default: ;
      endcase
    endfunction

    // Shift right, feedback into bit 31, key walks upward from bit 0
    function logic [31:0] encrypt_block(logic [31:0] blk, logic [15:0] n);
      logic [4:0] idx;
      logic [5:0] kpos;
      logic       fb;
      for (int unsigned i = 0; i < n; i++) begin
        kpos = ENC_KEY_START + 6'(i);
        idx  = {blk[31], blk[26], blk[20], blk[9], blk[1]};
        fb   = key[kpos] ^ blk[16] ^ blk[0] ^ nlf[idx];
        blk  = {fb, blk[31:1]};
      end
      return blk;
    endfunction

    // Shift left, feedback into bit 0, key walks downward from bit 15
    function logic [31:0] decrypt_block(logic [31:0] blk, logic [15:0] n);
      logic [4:0] idx;
      logic [5:0] kpos;
      logic       fb;
      for (int unsigned i = 0; i < n; i++) begin
        kpos = DEC_KEY_START - 6'(i);
        idx  = {blk[30], blk[25], blk[19], blk[8], blk[0]};
        fb   = key[kpos] ^ blk[31] ^ blk[15] ^ nlf[idx];
        blk  = {blk[30:0], fb};
      end
      return blk;
    endfunction

    // Work out the result of an accepted item and queue it
    function void note_item(logic [1:0] cmd, logic [31:0] blk, logic [31:0] ser);
      cipher_result_t res;
      logic [31:0]    sn;
      res = '0;
      sn  = ser & SERIAL_MASK;
      case (kcu_cmd_e'(cmd))
        CMD_ENCRYPT: res.block = encrypt_block(blk, rounds);
        CMD_DECRYPT: res.block = decrypt_block(blk, rounds);
        CMD_NORMAL_KEYGEN: begin
          res.dkey[31:0]  = decrypt_block(sn | NORMAL_LOW_TAG, KEYGEN_ROUNDS);
          res.dkey[63:32] = decrypt_block(sn | NORMAL_HIGH_TAG, KEYGEN_ROUNDS);
        end
        default: begin
          res.dkey[31:0]  = decrypt_block(blk, KEYGEN_ROUNDS);
          res.dkey[63:32] = decrypt_block(sn, KEYGEN_ROUNDS);
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    // Compare an accepted result with the oldest prediction
    function void check_result(logic [31:0] blk, logic [63:0] dkey);
      cipher_result_t exp_res;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("unexpected result block_out %h derived_key %h", blk, dkey));
        return;
      end
      exp_res = expected_q.pop_front();
      if (blk !== exp_res.block || dkey !== exp_res.dkey)
        note_failure($sformatf("block_out exp %h got %h, derived_key exp %h got %h",
                               exp_res.block, blk, exp_res.dkey, dkey));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void check_leftovers();
      if (expected_q.size() != 0)
        note_failure($sformatf("%0d results never arrived", expected_q.size()));
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
// Testbench top for keeloq_cipher_unit_top: directed and random items under
// several key, round count and table settings. Depends on kcu_pkg, kcu_if and
// keeloq_check_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kcu_pkg::*;
  import keeloq_check_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam int unsigned WATCHDOG_LIMIT = 250000;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 140;
  localparam int unsigned TAIL_CYCLES    = 1100;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [63:0]          pwdata;
  logic [63:0]          prdata;
  logic                 pready;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles = 0;

  keeloq_scoreboard sb;

  kcu_in_if  in_ch ();
  kcu_out_if out_ch ();

  keeloq_cipher_unit_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Randomly stall the result channel
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watch both channels, feed the scoreboard, and catch hangs
  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready)
      sb.note_item(in_ch.command, in_ch.block_in, in_ch.serial_in);
    if (out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.block_out, out_ch.derived_key);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(idle_mode_e mode);
    idle_pct  = (mode == IDLE_SENDER)   ? 82 : (mode == IDLE_BOTH) ? 21 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 82 : (mode == IDLE_BOTH) ? 21 : 0;
  endtask

  // Setup phase, then access phase held until pready, then back to idle
  task automatic reg_write(logic [1:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(kcu_cmd_e cmd, logic [31:0] blk, logic [31:0] ser);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.block_in  <= blk;
    in_ch.serial_in <= ser;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [63:0] key, logic [15:0] rounds, logic [31:0] table_word);
    drain();
    reg_write(REG_CIPHER_KEY, key);
    reg_write(REG_ROUND_COUNT, {48'b0, rounds});
    reg_write(REG_NLF_TABLE, {32'b0, table_word});
  endtask

  initial begin
    kcu_cmd_e    cmd;
    logic [15:0] rounds;
    logic [31:0] table_word;
    int unsigned roll;

    sb           = new();
    idle_pct     = 0;
    stall_pct    = 0;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_ENCRYPT;
    in_ch.block_in  <= '0;
    in_ch.serial_in <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings first
    set_idling(IDLE_NONE);
    send_item(CMD_ENCRYPT, 32'h0, 32'h0);
    send_item(CMD_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(CMD_NORMAL_KEYGEN, 32'h0, 32'h0);
    send_item(CMD_SECURE_KEYGEN, 32'hFFFFFFFF, 32'hFFFFFFFF);

    // Zero rounds pass the block through; key generation keeps its fixed rounds
    set_config('1, 16'd0, 32'h0);
    send_item(CMD_ENCRYPT, 32'hA5A5A5A5, 32'h0);
    send_item(CMD_DECRYPT, 32'h12345678, 32'hFFFFFFFF);
    send_item(CMD_NORMAL_KEYGEN, 32'h0, 32'hFFFFFFFF);
    send_item(CMD_SECURE_KEYGEN, 32'h0, 32'hF0000000);

    // Single round with an all-ones table
    set_config(64'h0123456789ABCDEF, 16'd1, 32'hFFFFFFFF);
    send_item(CMD_ENCRYPT, 32'h80000001, 32'h5A5A5A5A);
    send_item(CMD_DECRYPT, 32'h80000001, 32'hA5A5A5A5);

    // Largest round count, key wraps many times
    set_config({$urandom, $urandom}, 16'hFFFF, NLF_TABLE_RST);
    send_item(CMD_ENCRYPT, $urandom, $urandom);
    send_item(CMD_DECRYPT, $urandom, $urandom);

    // One full key cycle with a single key bit set
    set_config(64'h1, 16'd64, $urandom);
    send_item(CMD_ENCRYPT, 32'hDEADBEEF, 32'h0);
    send_item(CMD_DECRYPT, 32'hDEADBEEF, 32'h0);
    send_item(CMD_NORMAL_KEYGEN, 32'hFFFFFFFF, 32'hF0ABCDEF);
    send_item(CMD_SECURE_KEYGEN, 32'h0ABCDEF0, 32'h0FFFFFFF);

    // Random phases, each under its own settings and idling mode
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0, 4:    rounds = 16'd528;
        1:       rounds = 16'd1;
        2:       rounds = 16'd0;
        6:       rounds = 16'd64;
        5:       rounds = 16'($urandom_range(0, 96));
        default: rounds = 16'($urandom_range(2, 48));
      endcase
      table_word = (phase == 0) ? NLF_TABLE_RST : $urandom;
      set_config({$urandom, $urandom}, rounds, table_word);
      set_idling(idle_mode_e'(phase % 4));
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 44)      cmd = CMD_ENCRYPT;
        else if (roll < 88) cmd = CMD_DECRYPT;
        else if (roll < 94) cmd = CMD_NORMAL_KEYGEN;
        else                cmd = CMD_SECURE_KEYGEN;
        send_item(cmd, $urandom, $urandom);
      end
    end

    // Let any stray result show up, then decide
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.check_leftovers();
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kcu_pkg.sv
design/kcu_if.sv
design/kcu_cfg_regs.sv
design/kcu_datapath.sv
design/kcu_ctrl.sv
design/keeloq_cipher_unit_top.sv
sim/keeloq_check_pkg.sv
sim/tb_top.sv
